### design/alpha_bounding_box_scanner_assert.svh
// Assertion macros for the checker file of the bounding box scanner.
`ifndef ALPHA_BOUNDING_BOX_SCANNER_ASSERT_SVH
`define ALPHA_BOUNDING_BOX_SCANNER_ASSERT_SVH

// Clocked assertion, muted while reset is asserted.
`define ABBS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define ABBS_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

### design/abbs_pkg.sv
// Shared types and constants of the alpha bounding box scanner.
package abbs_pkg;

  localparam int MAX_DIMENSION_DEF = 4096;

  // Pixel layout
  localparam int PIXEL_W   = 32;
  localparam int ALPHA_LSB = 24;
  localparam int ALPHA_W   = 8;

  // Configuration port
  localparam int CFG_DATA_W  = 13;
  localparam int CFG_INDEX_W = 1;
  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

  // Result layout
  localparam int START_W  = 12;  // left_edge, top_edge
  localparam int END_W    = 13;  // right_edge, bottom_edge
  localparam int FIELDS_W = 2 * START_W + 2 * END_W;
  localparam int OUT_DATA_W = ((FIELDS_W + 7) / 8) * 8;
  localparam int OUT_PAD_W  = OUT_DATA_W - FIELDS_W;
  localparam int OUT_USER_W = 1;

  // Queue between front and back
  localparam int QUEUE_DEPTH = 4;

  // Classification of one pixel, passed from front to back
  typedef struct packed {
    logic opaque;     // alpha is nonzero
    logic frame_end;  // last pixel of the frame
  } abbs_ctrl_t;

endpackage

### design/abbs_front.sv
// Front part: configuration, raster position counters and pixel classification.
module abbs_front #(
  parameter int MAX_DIMENSION = abbs_pkg::MAX_DIMENSION_DEF,
  parameter int CW            = $clog2(MAX_DIMENSION)
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [abbs_pkg::CFG_INDEX_W-1:0]  cfg_index_i,
  input  logic [abbs_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  logic                              pix_valid_i,
  output logic                              pix_ready_o,
  input  logic [abbs_pkg::PIXEL_W-1:0]      pix_data_i,
  output logic                              push_valid_o,
  input  logic                              push_ready_i,
  output logic [CW-1:0]                     push_col_o,
  output logic [CW-1:0]                     push_row_o,
  output abbs_pkg::abbs_ctrl_t              push_ctrl_o
);
  import abbs_pkg::*;

  logic [CW-1:0] col_last_q, row_last_q, cfg_last_d;
  logic [CW-1:0] col_q, col_d, row_q, row_d;
  logic [31:0]   cfg_val;
  logic          last_col, last_row, accept;

  // Last index of a dimension: zero treated as one, clamp to MAX_DIMENSION
  always_comb begin
    cfg_val = 32'(cfg_data_i);
    if (cfg_val == 32'd0) begin
      cfg_last_d = '0;
    end else if (cfg_val > 32'(MAX_DIMENSION)) begin
      cfg_last_d = CW'(MAX_DIMENSION - 1);
    end else begin
      cfg_last_d = CW'(cfg_val - 32'd1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_last_q <= '0;
      row_last_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_IMAGE_WIDTH:  col_last_q <= cfg_last_d;
        REG_IMAGE_HEIGHT: row_last_q <= cfg_last_d;
        default:          ;
      endcase
    end
  end

  assign last_col = col_q >= col_last_q;
  assign last_row = row_q >= row_last_q;
  assign accept   = pix_valid_i && push_ready_i;

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (accept) begin
      if (last_col && last_row) begin
        col_d = '0;
        row_d = '0;
      end else if (last_col) begin
        col_d = '0;
        row_d = row_q + 1'b1;
      end else begin
        col_d = col_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  assign pix_ready_o            = push_ready_i;
  assign push_valid_o           = pix_valid_i;
  assign push_col_o             = col_q;
  assign push_row_o             = row_q;
  assign push_ctrl_o.opaque     = pix_data_i[ALPHA_LSB +: ALPHA_W] != '0;
  assign push_ctrl_o.frame_end  = last_col && last_row;

endmodule

### design/abbs_queue.sv
// Small first-in first-out queue between the front and back parts.
module abbs_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = abbs_pkg::QUEUE_DEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output logic [WIDTH-1:0] pop_data_o
);
  import abbs_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wr_ptr_q, rd_ptr_q;
  logic [NW-1:0]    count_q;
  logic             push, pop;

  assign push_ready_o = count_q != NW'(DEPTH);
  assign pop_valid_o  = count_q != '0;
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        count_q <= count_q + 1'b1;
      end else if (pop && !push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

### design/abbs_back.sv
// Back part: running bounding box and the registered trim result.
module abbs_back #(
  parameter int MAX_DIMENSION = abbs_pkg::MAX_DIMENSION_DEF,
  parameter int CW            = $clog2(MAX_DIMENSION)
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           pop_valid_i,
  output logic                           pop_ready_o,
  input  logic [CW-1:0]                  pop_col_i,
  input  logic [CW-1:0]                  pop_row_i,
  input  abbs_pkg::abbs_ctrl_t           pop_ctrl_i,
  output logic                           res_valid_o,
  input  logic                           res_ready_i,
  output logic [abbs_pkg::START_W-1:0]   left_edge_o,
  output logic [abbs_pkg::START_W-1:0]   top_edge_o,
  output logic [abbs_pkg::END_W-1:0]     right_edge_o,
  output logic [abbs_pkg::END_W-1:0]     bottom_edge_o,
  output logic                           is_empty_o
);
  import abbs_pkg::*;

  logic          any_q, any_d;
  logic [CW-1:0] min_col_q, max_col_q, min_row_q, max_row_q;
  logic [CW-1:0] min_col_d, max_col_d, min_row_d, max_row_d;
  logic [31:0]   left_w, top_w, right_w, bottom_w;
  logic          pop, first;
  logic          valid_q;
  logic [START_W-1:0] left_q, top_q;
  logic [END_W-1:0]   right_q, bottom_q;
  logic               empty_q;

  // Only a frame's last pixel has to wait for the result register
  assign pop_ready_o = !pop_ctrl_i.frame_end || !valid_q || res_ready_i;
  assign pop         = pop_valid_i && pop_ready_o;
  assign first       = pop_ctrl_i.opaque && !any_q;
  assign any_d       = any_q || pop_ctrl_i.opaque;

  // Widen the box; the first opaque pixel seeds all four bounds
  always_comb begin
    min_col_d = min_col_q;
    max_col_d = max_col_q;
    min_row_d = min_row_q;
    max_row_d = max_row_q;
    if (first) begin
      min_col_d = pop_col_i;
      max_col_d = pop_col_i;
      min_row_d = pop_row_i;
      max_row_d = pop_row_i;
    end else if (pop_ctrl_i.opaque) begin
      if (pop_col_i < min_col_q) min_col_d = pop_col_i;
      if (pop_col_i > max_col_q) max_col_d = pop_col_i;
      if (pop_row_i < min_row_q) min_row_d = pop_row_i;
      if (pop_row_i > max_row_q) max_row_d = pop_row_i;
    end
  end

  assign left_w   = 32'(min_col_d);
  assign top_w    = 32'(min_row_d);
  assign right_w  = 32'(max_col_d) + 32'd1;
  assign bottom_w = 32'(max_row_d) + 32'd1;

  always_ff @(posedge clk_i) begin
    if (pop) begin
      min_col_q <= min_col_d;
      max_col_q <= max_col_d;
      min_row_q <= min_row_d;
      max_row_q <= max_row_d;
    end
    if (pop && pop_ctrl_i.frame_end) begin
      left_q   <= any_d ? left_w[START_W-1:0]   : '0;
      top_q    <= any_d ? top_w[START_W-1:0]    : '0;
      right_q  <= any_d ? right_w[END_W-1:0]    : '0;
      bottom_q <= any_d ? bottom_w[END_W-1:0]   : '0;
      empty_q  <= !any_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      any_q   <= 1'b0;
      valid_q <= 1'b0;
    end else begin
      if (pop) begin
        any_q <= pop_ctrl_i.frame_end ? 1'b0 : any_d;
      end
      if (pop && pop_ctrl_i.frame_end) begin
        valid_q <= 1'b1;
      end else if (res_ready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  assign res_valid_o   = valid_q;
  assign left_edge_o   = left_q;
  assign top_edge_o    = top_q;
  assign right_edge_o  = right_q;
  assign bottom_edge_o = bottom_q;
  assign is_empty_o    = empty_q;

endmodule

### design/alpha_bounding_box_scanner.sv
// Alpha bounding box scanner: trim rectangle of the opaque pixels of a frame.
//
// Pixels enter in raster order, one item per clock while the queue has room.
// The front part keeps the column and row counters against the configured
// width and height (zero counts as one, values above MAX_DIMENSION are clamped
// to it) and tags each pixel as opaque (alpha in bits 31..24 nonzero) and as
// the frame's last pixel. A four-entry queue carries the tagged pixels to the
// back part, which widens a running min/max box in one compare per bound and
// cycle. On the last pixel the back part registers one result item: left,
// top, exclusive right and exclusive bottom, or all zeros with is_empty set
// when no pixel was opaque; the box then starts afresh. The frame's last pixel
// enters the queue and, once popped, loads the result register that drives
// m_axis_tvalid. Pixels keep flowing while a result waits; only the next
// frame's last pixel holds at the queue output, and the input stalls once the
// queue fills behind it. Write the size registers only while the block is
// idle. No clearing pass follows reset.
module alpha_bounding_box_scanner #(
  parameter int MAX_DIMENSION = abbs_pkg::MAX_DIMENSION_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Size registers
  input  logic                              cfg_we_i,
  input  logic [abbs_pkg::CFG_INDEX_W-1:0]  cfg_index_i,
  input  logic [abbs_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  // Pixel stream
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [abbs_pkg::PIXEL_W-1:0]      s_axis_tdata,  // [31:0] pixel_word
  // Result stream
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [11:0] left_edge, [23:12] top_edge, [36:24] right_edge, [49:37] bottom_edge
  output logic [abbs_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  output logic [abbs_pkg::OUT_USER_W-1:0]   m_axis_tuser   // [0] is_empty
);
  import abbs_pkg::*;

  localparam int CW = $clog2(MAX_DIMENSION);
  localparam int QW = 2 * CW + $bits(abbs_ctrl_t);

  logic          push_valid, push_ready, pop_valid, pop_ready;
  logic [CW-1:0] push_col, push_row, pop_col, pop_row;
  abbs_ctrl_t    push_ctrl, pop_ctrl;
  logic [QW-1:0] push_data, pop_data;
  logic [START_W-1:0] left_edge, top_edge;
  logic [END_W-1:0]   right_edge, bottom_edge;
  logic               is_empty;

  abbs_front #(.MAX_DIMENSION(MAX_DIMENSION), .CW(CW)) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .pix_valid_i  (s_axis_tvalid),
    .pix_ready_o  (s_axis_tready),
    .pix_data_i   (s_axis_tdata),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_col_o   (push_col),
    .push_row_o   (push_row),
    .push_ctrl_o  (push_ctrl)
  );

  // Pack position and tags into one queue entry
  assign push_data = {push_col, push_row, push_ctrl};
  assign {pop_col, pop_row, pop_ctrl} = pop_data;

  abbs_queue #(.WIDTH(QW), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  abbs_back #(.MAX_DIMENSION(MAX_DIMENSION), .CW(CW)) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .pop_valid_i   (pop_valid),
    .pop_ready_o   (pop_ready),
    .pop_col_i     (pop_col),
    .pop_row_i     (pop_row),
    .pop_ctrl_i    (pop_ctrl),
    .res_valid_o   (m_axis_tvalid),
    .res_ready_i   (m_axis_tready),
    .left_edge_o   (left_edge),
    .top_edge_o    (top_edge),
    .right_edge_o  (right_edge),
    .bottom_edge_o (bottom_edge),
    .is_empty_o    (is_empty)
  );

  assign m_axis_tdata = {{OUT_PAD_W{1'b0}}, bottom_edge, right_edge, top_edge, left_edge};
  assign m_axis_tuser = is_empty;

endmodule

### design/abbs_checker.sv
// Port-level checker of the bounding box scanner and its bind statement.
`include "alpha_bounding_box_scanner_assert.svh"

module abbs_checker #(
  parameter int MAX_DIMENSION = abbs_pkg::MAX_DIMENSION_DEF
) (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              m_axis_tvalid,
  input logic                              m_axis_tready,
  input logic [abbs_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  input logic [abbs_pkg::OUT_USER_W-1:0]   m_axis_tuser
);
  import abbs_pkg::*;

  localparam bit NoWrap = MAX_DIMENSION <= (1 << START_W);

  logic [START_W-1:0] left_edge, top_edge;
  logic [END_W-1:0]   right_edge, bottom_edge;

  assign left_edge   = m_axis_tdata[START_W-1:0];
  assign top_edge    = m_axis_tdata[2*START_W-1:START_W];
  assign right_edge  = m_axis_tdata[2*START_W+END_W-1:2*START_W];
  assign bottom_edge = m_axis_tdata[FIELDS_W-1:2*START_W+END_W];

  // Hold a stalled result
  `ABBS_ASSERT(a_res_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "result changed while stalled")
  // No result while reset is applied
  `ABBS_ASSERT_RST(a_rst_quiet, !rst_ni |-> !m_axis_tvalid, "result valid during reset")
  // An empty frame reports a zero rectangle
  `ABBS_ASSERT(a_empty_zero, m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == '0, "empty frame with nonzero edges")
  // A filled frame reports a nonempty rectangle
  `ABBS_ASSERT(a_box_order, NoWrap && m_axis_tvalid && !m_axis_tuser[0] |-> (13'(left_edge) < right_edge) && (13'(top_edge) < bottom_edge), "trim rectangle inverted")

endmodule

bind alpha_bounding_box_scanner abbs_checker #(.MAX_DIMENSION(MAX_DIMENSION)) u_abbs_checker (.*);
